// ----- src/fsel_pkg.sv -----
`timescale 1ns / 1ps
package fsel_pkg;

  localparam int MAX_TAPS_DEF    = 75;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 18;
  localparam int ROM_FRAC        = 16;
  localparam int ROM_DEPTH       = 87;
  localparam int NUM_MODES       = 5;

  typedef enum logic [2:0] {
    MODE_SUM4 = 3'd0,
    MODE_LP17 = 3'd1,
    MODE_LP33 = 3'd2,
    MODE_LP41 = 3'd3,
    MODE_LP75 = 3'd4
  } mode_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] sample_in;
    logic                              sample_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] filtered_sample;
    logic                              result_last;
  } out_item_t;

  function automatic logic signed [17:0] coef_rom(input logic [6:0] a);
    logic signed [17:0] r;
    case (a)
      7'd0: r = 65536;   7'd1: r = 65536;
      7'd2: r = -723;    7'd3: r = -1093;   7'd4: r = -1088;   7'd5: r = -55;
      7'd6: r = 2311;    7'd7: r = 5781;    7'd8: r = 9546;    7'd9: r = 12475;
      7'd10: r = 13581;
      7'd11: r = -44;    7'd12: r = -184;   7'd13: r = -430;   7'd14: r = -663;
      7'd15: r = -636;   7'd16: r = -139;   7'd17: r = 729;    7'd18: r = 1429;
      7'd19: r = 1219;   7'd20: r = -236;   7'd21: r = -2304;  7'd22: r = -3393;
      7'd23: r = -1787;  7'd24: r = 3112;   7'd25: r = 10003;  7'd26: r = 16076;
      7'd27: r = 18496;
      7'd28: r = 464;    7'd29: r = 460;    7'd30: r = 579;    7'd31: r = 616;
      7'd32: r = 527;    7'd33: r = 291;    7'd34: r = -87;    7'd35: r = -565;
      7'd36: r = -1059;  7'd37: r = -1461;  7'd38: r = -1647;  7'd39: r = -1503;
      7'd40: r = -947;   7'd41: r = 46;     7'd42: r = 1436;   7'd43: r = 3112;
      7'd44: r = 4905;   7'd45: r = 6609;   7'd46: r = 8015;   7'd47: r = 8941;
      7'd48: r = 9264;
      7'd49: r = 386;    7'd50: r = 140;    7'd51: r = 121;    7'd52: r = 67;
      7'd53: r = -22;    7'd54: r = -139;   7'd55: r = -270;   7'd56: r = -397;
      7'd57: r = -497;   7'd58: r = -550;   7'd59: r = -538;   7'd60: r = -450;
      7'd61: r = -290;   7'd62: r = -69;    7'd63: r = 186;    7'd64: r = 439;
      7'd65: r = 649;    7'd66: r = 775;    7'd67: r = 783;    7'd68: r = 654;
      7'd69: r = 387;    7'd70: r = 2;      7'd71: r = -457;   7'd72: r = -927;
      7'd73: r = -1332;  7'd74: r = -1594;  7'd75: r = -1637;  7'd76: r = -1405;
      7'd77: r = -868;   7'd78: r = -27;    7'd79: r = 1080;   7'd80: r = 2383;
      7'd81: r = 3782;   7'd82: r = 5160;   7'd83: r = 6395;   7'd84: r = 7373;
      7'd85: r = 7999;   7'd86: r = 8216;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] set_base(input logic [2:0] m);
    logic [6:0] b;
    case (m)
      MODE_LP17: b = 7'd2;
      MODE_LP33: b = 7'd11;
      MODE_LP41: b = 7'd28;
      MODE_LP75: b = 7'd49;
      default:   b = 7'd0;
    endcase
    return b;
  endfunction

  function automatic logic [6:0] set_taps(input logic [2:0] m);
    logic [6:0] t;
    case (m)
      MODE_LP17: t = 7'd17;
      MODE_LP33: t = 7'd33;
      MODE_LP41: t = 7'd41;
      MODE_LP75: t = 7'd75;
      default:   t = 7'd4;
    endcase
    return t;
  endfunction

endpackage

// ----- src/fir_filter_selectable_taps.sv -----
`timescale 1ns / 1ps
// channel | ports                          | payload
// input   | in_valid, in_ready, in_item    | sample_in, sample_last
// output  | out_valid, out_ready, out_item | filtered_sample, result_last
// config  | cfg_we, cfg_data               | filter_mode
// A result is loaded into the output register after its item is taken and the
// n taps of an n-tap set (4 to 75) are summed by the single multiply-accumulate
// unit, reading one history entry per cycle; the next item is taken after that.
// A finished item waits while the output register holds a stalled item; no
// item is taken meanwhile.
// A mode write clears the history with a pass over all MAX_TAPS entries during
// which no item is accepted. Reset runs the same pass.
module fir_filter_selectable_taps #(
  parameter int MAX_TAPS    = fsel_pkg::MAX_TAPS_DEF,
  parameter int COEF_BITS   = fsel_pkg::COEF_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fsel_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fsel_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data
);

  localparam int SAMPLE_BITS = fsel_pkg::SAMPLE_BITS_DEF;
  localparam int AW   = $clog2(MAX_TAPS);
  localparam int CF   = COEF_BITS - 2;
  localparam int ACCW = 64;

  logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];

  fsel_pkg::state_t state_r, state_nxt;
  logic [2:0]    mode_r;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [6:0]    k_r, k_nxt;
  logic [2:0]    tail_r, tail_nxt;
  logic [AW:0]   clr_cnt_r;
  logic          clearing;
  logic [6:0]    full, n;
  logic [6:0]    h;
  logic [6:0]    base;
  logic          last_r;
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic          rd_v_r;
  logic signed [17:0] coef_r;
  logic          acc_clr;
  logic signed [ACCW-1:0] acc, rnd;
  logic signed [ACCW-CF-1:0] q;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic          out_valid_r;
  fsel_pkg::out_item_t out_r;
  logic [AW-1:0] wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic          wr_en;
  logic          take;
  logic [AW-1:0] pos;

  assign clearing = (clr_cnt_r < (AW+1)'(MAX_TAPS));
  assign full = fsel_pkg::set_taps(mode_r);
  assign n    = (32'(full) < MAX_TAPS) ? full : 7'(MAX_TAPS);
  assign base = fsel_pkg::set_base(mode_r);
  assign pos  = (32'(wpos_r) >= 32'(n)) ? '0 : wpos_r;
  assign in_ready = (state_r == fsel_pkg::ST_IDLE) && !clearing && !cfg_we;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    wr_en   = clearing || take;
    wr_addr = clearing ? clr_cnt_r[AW-1:0] : pos;
    wr_data = clearing ? '0 : in_item.sample_in;
  end

  // history memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en && (32'(wr_addr) < MAX_TAPS)) begin
      hist[wr_addr] <= wr_data;
    end
    rd_r <= hist[idx_r];
  end

  always_comb begin
    h = (k_r < full - 7'd1 - k_r) ? k_r : full - 7'd1 - k_r;
  end

  always_ff @(posedge clk) begin
    rd_v_r <= (state_r == fsel_pkg::ST_MAC) && (k_r < n);
    coef_r <= fsel_pkg::coef_rom(base + h);
  end

  fsel_mac #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS), .ACC_BITS(ACCW)) u_mac (
    .clk      (clk),
    .clr      (acc_clr),
    .en       (rd_v_r),
    .smp      (rd_r),
    .rom_coef (coef_r),
    .acc      (acc)
  );

  assign acc_clr = take;

  always_comb begin
    state_nxt = state_r;
    wpos_nxt  = wpos_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    tail_nxt  = tail_r;
    case (state_r)
      fsel_pkg::ST_IDLE: begin
        if (take) begin
          state_nxt = fsel_pkg::ST_MAC;
          idx_nxt   = pos;
          k_nxt     = '0;
          tail_nxt  = '0;
          wpos_nxt  = (pos == '0) ? AW'(n - 7'd1) : pos - 1'b1;
        end
      end
      fsel_pkg::ST_MAC: begin
        if (k_r < n) begin
          k_nxt   = k_r + 7'd1;
          idx_nxt = (32'(idx_r) + 1 >= 32'(n)) ? '0 : idx_r + 1'b1;
        end else begin
          tail_nxt = tail_r + 3'd1;
          if (tail_r == 3'd2) begin
            state_nxt = fsel_pkg::ST_DONE;
          end
        end
      end
      fsel_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = fsel_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fsel_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsel_pkg::ST_IDLE;
      mode_r  <= '0;
      wpos_r  <= '0;
      idx_r   <= '0;
      k_r     <= '0;
      tail_r  <= '0;
    end else if (cfg_we) begin
      mode_r  <= cfg_data;
      wpos_r  <= '0;
      state_r <= fsel_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      wpos_r  <= wpos_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      last_r <= in_item.sample_last;
    end
  end

  always_comb begin
    rnd = acc + (ACCW'(1) <<< (CF - 1));
    q   = rnd[ACCW-1:CF];
    if (q > (ACCW-CF)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1)) begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (q < -((ACCW-CF)'(64'sd1 <<< (SAMPLE_BITS - 1)))) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == fsel_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fsel_pkg::ST_DONE && (!out_valid_r || out_ready)) begin
      out_r.filtered_sample <= sat;
      out_r.result_last     <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- src/fsel_mac.sv -----
`timescale 1ns / 1ps
module fsel_mac #(
  parameter int SAMPLE_BITS = fsel_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = fsel_pkg::COEF_BITS_DEF,
  parameter int ACC_BITS    = 64
) (
  input  logic                          clk,
  input  logic                          clr,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] smp,
  input  logic signed [17:0]            rom_coef,
  output logic signed [ACC_BITS-1:0]    acc
);

  localparam int CF = COEF_BITS - 2;
  localparam int SH = (fsel_pkg::ROM_FRAC > CF) ? fsel_pkg::ROM_FRAC - CF : 0;
  localparam int UP = (CF > fsel_pkg::ROM_FRAC) ? CF - fsel_pkg::ROM_FRAC : 0;

  logic signed [COEF_BITS-1:0]             coef;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_r;
  logic                                    prod_v_r;
  logic signed [ACC_BITS-1:0]              acc_r;
  logic signed [49:0]                      wide;
  logic signed [49:0]                      mag;
  logic signed [49:0]                      half;

  always_comb begin
    half = (SH > 0) ? (50'sd1 <<< (SH > 0 ? SH - 1 : 0)) : 50'sd0;
    wide = 50'(rom_coef);
    mag  = (wide < 0) ? -wide : wide;
    if (SH > 0) begin
      mag = (mag + half) >>> SH;
      coef = COEF_BITS'((wide < 0) ? -mag : mag);
    end else begin
      coef = COEF_BITS'(wide <<< UP);
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= smp * coef;
    prod_v_r <= en;
    if (clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + ACC_BITS'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

// ----- src/fsel_checker.sv -----
`timescale 1ns / 1ps
module fsel_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fsel_pkg::out_item_t out_item,
  input logic                cfg_we
);

  a_no_take_on_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_ready) else $error("input taken during mode write");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second item taken too soon");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !$rose(out_valid))
    else $error("result appeared too soon");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind fir_filter_selectable_taps fsel_checker u_fsel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_we    (cfg_we)
);

// ----- sim/fir_filter_selectable_taps_tb.sv -----
`timescale 1ns / 1ps
module fir_filter_selectable_taps_tb;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  fsel_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  fsel_pkg::out_item_t out_item;
  logic cfg_we;
  logic [2:0] cfg_data;

  fir_filter_selectable_taps u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  logic signed [15:0] hist [0:74];
  int unsigned wpos;
  logic [2:0] mode_reg;
  fsel_pkg::out_item_t filtered_q[$];
  int errors;
  int hold_off;
  bit stall_en;

  function automatic int tap_coef(int m, int k);
    int base;
    int taps;
    int h;
    int c;
    case (m)
      fsel_pkg::MODE_LP17: begin base = 2; taps = 17; end
      fsel_pkg::MODE_LP33: begin base = 11; taps = 33; end
      fsel_pkg::MODE_LP41: begin base = 28; taps = 41; end
      fsel_pkg::MODE_LP75: begin base = 49; taps = 75; end
      default: begin base = 0; taps = 4; end
    endcase
    h = (k < taps - 1 - k) ? k : taps - 1 - k;
    case (base + h)
      0, 1: c = 65536;
      2: c = -723; 3: c = -1093; 4: c = -1088; 5: c = -55; 6: c = 2311;
      7: c = 5781; 8: c = 9546; 9: c = 12475; 10: c = 13581;
      11: c = -44; 12: c = -184; 13: c = -430; 14: c = -663; 15: c = -636;
      16: c = -139; 17: c = 729; 18: c = 1429; 19: c = 1219; 20: c = -236;
      21: c = -2304; 22: c = -3393; 23: c = -1787; 24: c = 3112; 25: c = 10003;
      26: c = 16076; 27: c = 18496;
      28: c = 464; 29: c = 460; 30: c = 579; 31: c = 616; 32: c = 527;
      33: c = 291; 34: c = -87; 35: c = -565; 36: c = -1059; 37: c = -1461;
      38: c = -1647; 39: c = -1503; 40: c = -947; 41: c = 46; 42: c = 1436;
      43: c = 3112; 44: c = 4905; 45: c = 6609; 46: c = 8015; 47: c = 8941;
      48: c = 9264;
      49: c = 386; 50: c = 140; 51: c = 121; 52: c = 67; 53: c = -22;
      54: c = -139; 55: c = -270; 56: c = -397; 57: c = -497; 58: c = -550;
      59: c = -538; 60: c = -450; 61: c = -290; 62: c = -69; 63: c = 186;
      64: c = 439; 65: c = 649; 66: c = 775; 67: c = 783; 68: c = 654;
      69: c = 387; 70: c = 2; 71: c = -457; 72: c = -927; 73: c = -1332;
      74: c = -1594; 75: c = -1637; 76: c = -1405; 77: c = -868; 78: c = -27;
      79: c = 1080; 80: c = 2383; 81: c = 3782; 82: c = 5160; 83: c = 6395;
      84: c = 7373; 85: c = 7999; 86: c = 8216;
      default: c = 0;
    endcase
    return c;
  endfunction

  function automatic int mode_taps(int m);
    case (m)
      fsel_pkg::MODE_LP17: return 17;
      fsel_pkg::MODE_LP33: return 33;
      fsel_pkg::MODE_LP41: return 41;
      fsel_pkg::MODE_LP75: return 75;
      default: return 4;
    endcase
  endfunction

  function automatic fsel_pkg::out_item_t filter_step(fsel_pkg::in_item_t it);
    fsel_pkg::out_item_t r;
    int n;
    int unsigned pos;
    int unsigned idx;
    longint acc;
    longint q;
    n = mode_taps(mode_reg);
    pos = wpos;
    if (pos >= n) pos = 0;
    hist[pos] = it.sample_in;
    acc = 0;
    idx = pos;
    for (int k = 0; k < n; k++) begin
      acc += longint'(hist[idx]) * longint'(tap_coef(mode_reg, k));
      idx++;
      if (idx >= n) idx = 0;
    end
    wpos = (pos == 0) ? n - 1 : pos - 1;
    q = (acc + 64'sd32768) >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    r.filtered_sample = q[15:0];
    r.result_last = it.sample_last;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_sample(logic signed [15:0] s, logic last);
    fsel_pkg::in_item_t it;
    int g;
    it.sample_in = s;
    it.sample_last = last;
    g = gap_len();
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filtered_q.push_back(filter_step(it));
    @(negedge clk);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_mode(logic [2:0] m);
    drain();
    cfg_data <= m;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_reg = m;
    for (int i = 0; i < 75; i++) hist[i] = 0;
    wpos = 0;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      logic signed [15:0] s;
      case ($urandom_range(0, 5))
        0: s = 16'sh7fff;
        1: s = 16'sh8000;
        2: s = 16'($urandom_range(0, 400) - 200);
        default: s = 16'($urandom());
      endcase
      send_sample(s, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_extremes();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shffff, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shaaaa, 1'b1);
  endtask

  task automatic test_all_modes();
    for (int m = 0; m < 8; m++) begin
      write_mode(m[2:0]);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_random(12);
    end
  endtask

  task automatic test_rewrite_same();
    write_mode(fsel_pkg::MODE_LP17);
    send_random(10);
    write_mode(fsel_pkg::MODE_LP17);
    send_random(10);
  endtask

  task automatic test_backpressure();
    write_mode(fsel_pkg::MODE_SUM4);
    hold_off = 400;
    send_random(10);
  endtask

  task automatic test_random();
    for (int i = 0; i < 12; i++) begin
      write_mode(3'($urandom_range(0, 7)));
      send_random(30);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_item);
        errors++;
      end else begin
        fsel_pkg::out_item_t exp_item;
        exp_item = filtered_q.pop_front();
        if (out_item.filtered_sample !== exp_item.filtered_sample ||
            out_item.result_last !== exp_item.result_last) begin
          $display("%0t: expected %0d/%0b actual %0d/%0b", $time,
                   exp_item.filtered_sample, exp_item.result_last,
                   out_item.filtered_sample, out_item.result_last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!stall_en) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    errors = 0;
    hold_off = 0;
    stall_en = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mode_reg = fsel_pkg::MODE_SUM4;
    wpos = 0;
    for (int i = 0; i < 75; i++) hist[i] = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    stall_en = 1'b1;
    test_all_modes();
    test_rewrite_same();
    test_backpressure();
    test_random();
    write_mode(fsel_pkg::MODE_LP75);
    send_random(20);
    write_mode(fsel_pkg::MODE_SUM4);
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
